// ===== sv/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle (overlapping) implication, checked on every rising edge outside reset
`define WFCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wfcd assertion failed");

// next-cycle implication
`define WFCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wfcd assertion failed");

`endif

// ===== sv/wfcd_pkg.sv =====
package wfcd_pkg;

    localparam int ID_W  = 6;
    localparam int CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_DETECT = 2'd2
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WALK,
        ST_FETCH,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_clear;
        logic scan_inc;
        logic walk_start;
        logic mark;
        logic load_cur;
        logic set_hit;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_detect;
        logic start_valid;
        logic scan_last;
        logic cur_in_range;
        logic cur_visited;
        logic cur_has_edge;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/wait_for_cycle_detector.sv =====
// add, remove and unused codes: the result passes through the response state into
//   the output register, and the block then returns to idle for the next request
// detect: scans start ids one per cycle while no walk runs; each chain step is a walk
//   state and a fetch state (table read is registered)
// one request in flight; a new request is taken while the last result waits
// reset (aresetn low, synchronous) clears all edge flags and visit marks
`include "assert_macros.svh"

module wait_for_cycle_detector #(
    parameter int MAX_TXN = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wfcd_pkg::CMD_W-1:0]    s_cmd,
    input  logic [wfcd_pkg::ID_W-1:0]     s_txn_a,
    input  logic [wfcd_pkg::ID_W-1:0]     s_txn_b,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [wfcd_pkg::ID_W-1:0]     m_victim
);

    // command bundle from the sequencer, status bundle back from the datapath
    wfcd_pkg::ctrl_cmd_t  ctrl_cmd;
    wfcd_pkg::dp_status_t dp_status;

    // sequencer: idle, scan of start ids, chain walk, table fetch, result hand-off
    wfcd_ctrl u_ctrl (
        .clk     (aclk),
        .rstn    (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    // datapath: target table in ram, edge and visit flags in flops,
    // scan and walk pointers, result register feeding the output stage
    wfcd_dp #(
        .MAX_TXN (MAX_TXN)
    ) u_dp (
        .clk      (aclk),
        .rstn     (aresetn),
        .s_cmd    (s_cmd),
        .s_txn_a  (s_txn_a),
        .s_txn_b  (s_txn_b),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_found  (m_found),
        .m_victim (m_victim),
        .cmd      (ctrl_cmd),
        .status   (dp_status)
    );

    // a result without a cycle always carries a zero victim
    `WFCD_ASSERT_IMPL(a_victim_zero, aclk, aresetn, m_valid && !m_found, m_victim == '0)

endmodule

// ===== sv/wfcd_ram.sv =====
module wfcd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wfcd_ctrl.sv =====
`include "assert_macros.svh"

module wfcd_ctrl (
    input  logic                   clk,
    input  logic                   rstn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  wfcd_pkg::dp_status_t   status,
    output wfcd_pkg::ctrl_cmd_t    cmd
);

    wfcd_pkg::state_t state_reg;
    wfcd_pkg::state_t state_next;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= wfcd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wfcd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.is_detect ? wfcd_pkg::ST_SCAN : wfcd_pkg::ST_RESP;
                end
            end
            wfcd_pkg::ST_SCAN: begin
                if (status.start_valid) begin
                    state_next = wfcd_pkg::ST_WALK;
                end else if (status.scan_last) begin
                    state_next = wfcd_pkg::ST_RESP;
                end
            end
            wfcd_pkg::ST_WALK: begin
                if (status.cur_in_range && status.cur_visited) begin
                    state_next = wfcd_pkg::ST_RESP;
                end else if (status.cur_in_range && status.cur_has_edge) begin
                    state_next = wfcd_pkg::ST_FETCH;
                end else if (status.scan_last) begin
                    state_next = wfcd_pkg::ST_RESP;
                end else begin
                    state_next = wfcd_pkg::ST_SCAN;
                end
            end
            wfcd_pkg::ST_FETCH: begin
                state_next = wfcd_pkg::ST_WALK;
            end
            wfcd_pkg::ST_RESP: begin
                if (status.out_free) begin
                    state_next = wfcd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wfcd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            wfcd_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                cmd.scan_clear = s_valid && status.is_detect;
            end
            wfcd_pkg::ST_SCAN: begin
                cmd.walk_start = status.start_valid;
                cmd.scan_inc   = !status.start_valid && !status.scan_last;
            end
            wfcd_pkg::ST_WALK: begin
                if (status.cur_in_range && status.cur_visited) begin
                    cmd.set_hit = 1'b1;
                end else if (status.cur_in_range && status.cur_has_edge) begin
                    cmd.mark = 1'b1;
                end else begin
                    cmd.mark     = status.cur_in_range;
                    cmd.scan_inc = !status.scan_last;
                end
            end
            wfcd_pkg::ST_FETCH: begin
                cmd.load_cur = 1'b1;
            end
            wfcd_pkg::ST_RESP: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `WFCD_ASSERT_IMPL(a_fetch_after_walk, clk, rstn, state_reg == wfcd_pkg::ST_FETCH,
        $past(state_reg) == wfcd_pkg::ST_WALK)
    `WFCD_ASSERT_NEXT(a_accept_leaves_idle, clk, rstn, s_valid && s_ready,
        state_reg != wfcd_pkg::ST_IDLE)

endmodule

// ===== sv/wfcd_dp.sv =====
`include "assert_macros.svh"

module wfcd_dp #(
    parameter int MAX_TXN = 64
) (
    input  logic                           clk,
    input  logic                           rstn,
    input  logic [wfcd_pkg::CMD_W-1:0]     s_cmd,
    input  logic [wfcd_pkg::ID_W-1:0]      s_txn_a,
    input  logic [wfcd_pkg::ID_W-1:0]      s_txn_b,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic                           m_found,
    output logic [wfcd_pkg::ID_W-1:0]      m_victim,
    input  wfcd_pkg::ctrl_cmd_t            cmd,
    output wfcd_pkg::dp_status_t           status
);

    localparam int IDX_W = $clog2(MAX_TXN);
    localparam int ID_W  = wfcd_pkg::ID_W;

    logic [IDX_W-1:0]   scan_reg,      scan_next;
    logic [ID_W-1:0]    cur_reg,       cur_next;
    logic [MAX_TXN-1:0] edge_valid_reg, edge_valid_next;
    logic [MAX_TXN-1:0] visited_reg,   visited_next;
    logic               res_found_reg, res_found_next;
    logic [ID_W-1:0]    res_victim_reg, res_victim_next;
    logic               m_valid_reg,   m_valid_next;
    logic               m_found_reg,   m_found_next;
    logic [ID_W-1:0]    m_victim_reg,  m_victim_next;

    wfcd_pkg::cmd_code_t in_code;
    logic               a_in_range;
    logic [IDX_W-1:0]   a_idx;
    logic [IDX_W-1:0]   cur_idx;
    logic               ram_we;
    logic [ID_W-1:0]    ram_rdata;
    logic               do_add;
    logic               do_remove;

    assign in_code    = wfcd_pkg::cmd_code_t'(s_cmd);
    assign a_in_range = 32'(s_txn_a) < 32'(MAX_TXN);
    assign a_idx      = IDX_W'(s_txn_a);
    assign cur_idx    = IDX_W'(cur_reg);

    always_comb begin
        do_add    = 1'b0;
        do_remove = 1'b0;
        unique case (in_code)
            wfcd_pkg::CMD_ADD:    do_add    = cmd.accept && a_in_range;
            wfcd_pkg::CMD_REMOVE: do_remove = cmd.accept && a_in_range;
            default: begin
                do_add    = 1'b0;
                do_remove = 1'b0;
            end
        endcase
    end

    assign ram_we = do_add;

    wfcd_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_TXN)
    ) u_target_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (a_idx),
        .wdata (s_txn_b),
        .raddr (cur_idx),
        .rdata (ram_rdata)
    );

    always_comb begin
        scan_next       = scan_reg;
        cur_next        = cur_reg;
        edge_valid_next = edge_valid_reg;
        visited_next    = visited_reg;
        res_found_next  = res_found_reg;
        res_victim_next = res_victim_reg;

        if (do_add) begin
            edge_valid_next[a_idx] = 1'b1;
        end
        if (do_remove) begin
            edge_valid_next[a_idx] = 1'b0;
        end
        if (cmd.accept) begin
            res_found_next  = 1'b0;
            res_victim_next = '0;
        end
        if (cmd.scan_clear) begin
            scan_next = '0;
        end
        if (cmd.scan_inc) begin
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.walk_start) begin
            cur_next     = ID_W'(scan_reg);
            visited_next = '0;
        end
        if (cmd.mark) begin
            visited_next[cur_idx] = 1'b1;
        end
        if (cmd.load_cur) begin
            cur_next = ram_rdata;
        end
        if (cmd.set_hit) begin
            res_found_next  = 1'b1;
            res_victim_next = cur_reg;
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_found_next  = m_found_reg;
        m_victim_next = m_victim_reg;
        if (cmd.out_load) begin
            m_valid_next  = 1'b1;
            m_found_next  = res_found_reg;
            m_victim_next = res_victim_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            edge_valid_reg <= '0;
            visited_reg    <= '0;
            res_found_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            edge_valid_reg <= edge_valid_next;
            visited_reg    <= visited_next;
            res_found_reg  <= res_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        scan_reg       <= scan_next;
        cur_reg        <= cur_next;
        res_victim_reg <= res_victim_next;
        m_found_reg    <= m_found_next;
        m_victim_reg   <= m_victim_next;
    end

    assign status.is_detect    = (in_code == wfcd_pkg::CMD_DETECT);
    assign status.start_valid  = edge_valid_reg[scan_reg];
    assign status.scan_last    = (scan_reg == IDX_W'(MAX_TXN - 1));
    assign status.cur_in_range = 32'(cur_reg) < 32'(MAX_TXN);
    assign status.cur_visited  = visited_reg[cur_idx];
    assign status.cur_has_edge = edge_valid_reg[cur_idx];
    assign status.out_free     = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;
    assign m_victim = m_victim_reg;

    `WFCD_ASSERT_IMPL(a_victim_marked, clk, rstn, res_found_reg,
        visited_reg[IDX_W'(res_victim_reg)])

endmodule

// ===== sim/wait_for_cycle_detector_tb.sv =====
`timescale 1ns / 100ps

module wait_for_cycle_detector_tb;

    localparam int ID_W = wfcd_pkg::ID_W;
    localparam int CMD_W = wfcd_pkg::CMD_W;
    localparam int TXN_LIMIT = 64;
    localparam int HALF_PERIOD = 10;
    // cmd 3 has no package name; the block treats it as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES = 400;
    // quiet cycles after the last result, to catch stray results
    localparam int DRAIN_CYCLES = 20;
    // request counts where the random phase and the whole run stop
    localparam int RANDOM_TARGET = 1100;
    localparam int FINAL_TARGET = 1300;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] victim;
    } verdict_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CMD_W-1:0]  s_cmd;
    logic [ID_W-1:0]   s_txn_a;
    logic [ID_W-1:0]   s_txn_b;
    logic              m_valid;
    logic              m_ready;
    logic              m_found;
    logic [ID_W-1:0]   m_victim;

    // local copy of the waits-for table
    bit              edge_set [TXN_LIMIT] = '{default: 1'b0};
    logic [ID_W-1:0] edge_to  [TXN_LIMIT] = '{default: '0};

    // expected verdicts, oldest first
    verdict_t verdict_queue [$];

    int  requests_sent = 0;
    int  results_seen  = 0;
    int  failures      = 0;
    bit  idle_on       = 1'b1;
    bit  hold_off_req  = 1'b0;

    wait_for_cycle_detector #(
        .MAX_TXN (TXN_LIMIT)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_txn_a  (s_txn_a),
        .s_txn_b  (s_txn_b),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_found  (m_found),
        .m_victim (m_victim)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom_range(0, TXN_LIMIT - 1));
    endfunction

    // apply one request to the table copy and work out its verdict
    function automatic void compute_verdict(input logic [CMD_W-1:0] cmd,
                                            input logic [ID_W-1:0] a,
                                            input logic [ID_W-1:0] b,
                                            output verdict_t v);
        bit [TXN_LIMIT-1:0] seen;
        int start;
        int cur;
        bit stop;
        v = '0;
        case (cmd)
            wfcd_pkg::CMD_ADD: begin
                // ids past the table are dropped
                if (int'(a) < TXN_LIMIT) begin
                    edge_to[a] = b;
                    edge_set[a] = 1'b1;
                end
            end
            wfcd_pkg::CMD_REMOVE: begin
                if (int'(a) < TXN_LIMIT)
                    edge_set[a] = 1'b0;
            end
            wfcd_pkg::CMD_DETECT: begin
                // ascending start ids, marks cleared before every walk
                for (start = 0; start < TXN_LIMIT && !v.found; start++) begin
                    if (edge_set[start]) begin
                        seen = '0;
                        cur = start;
                        stop = 1'b0;
                        // a target past the table ends the walk unmarked
                        while (!stop && cur < TXN_LIMIT) begin
                            if (seen[cur]) begin
                                v.found = 1'b1;
                                v.victim = cur[ID_W-1:0];
                                stop = 1'b1;
                            end else begin
                                seen[cur] = 1'b1;
                                if (!edge_set[cur])
                                    stop = 1'b1;
                                else
                                    cur = int'(edge_to[cur]);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // offer one request, hold it until accepted, then log its verdict
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [ID_W-1:0] a,
                                input logic [ID_W-1:0] b);
        verdict_t v;
        // random sender gap, valid dropped for the gap
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_txn_a <= a;
        s_txn_b <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        compute_verdict(cmd, a, b, v);
        verdict_queue.push_back(v);
        requests_sent++;
    endtask

    // sender steps back until every outstanding result is in
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdict_queue.size() != 0);
    endtask

    // one random graph: chain over shuffled ids, maybe closed into a loop,
    // maybe broken, some noise, a detect, then maybe torn down again
    task automatic run_episode();
        logic [ID_W-1:0] order [TXN_LIMIT];
        logic [ID_W-1:0] tmp;
        int j;
        int len;
        int noise;
        for (int i = 0; i < TXN_LIMIT; i++)
            order[i] = ID_W'(i);
        for (int i = TXN_LIMIT - 1; i > 0; i--) begin
            j = int'($urandom_range(0, i));
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        // mostly short chains, now and then one over every id
        len = ($urandom_range(0, 15) == 0) ? TXN_LIMIT : int'($urandom_range(2, 12));
        for (int i = 0; i < len - 1; i++)
            send_request(wfcd_pkg::CMD_ADD, order[i], order[i + 1]);
        // close the tail back onto the chain (self loop included)
        if ($urandom_range(0, 1) == 1)
            send_request(wfcd_pkg::CMD_ADD, order[len - 1],
                         order[$urandom_range(0, len - 1)]);
        // broken chain
        if ($urandom_range(0, 3) == 0)
            send_request(wfcd_pkg::CMD_REMOVE, order[$urandom_range(0, len - 1)],
                         rand_id());
        noise = int'($urandom_range(0, 3));
        repeat (noise)
            send_request(CMD_W'($urandom_range(0, 3)), rand_id(), rand_id());
        send_request(wfcd_pkg::CMD_DETECT, rand_id(), rand_id());
        if ($urandom_range(0, 1) == 1) begin
            for (int i = 0; i < len; i++)
                send_request(wfcd_pkg::CMD_REMOVE, order[i], rand_id());
        end
    endtask

    // edge cases by hand: empty table, no-op commands, overwrite, loops
    task automatic test_directed();
        send_request(wfcd_pkg::CMD_DETECT, 6'd0, 6'd0);     // empty table
        send_request(wfcd_pkg::CMD_REMOVE, 6'd5, 6'd63);    // remove with no edge
        send_request(CMD_UNUSED, 6'd63, 6'd63);
        send_request(wfcd_pkg::CMD_ADD, 6'd0, 6'd63);
        send_request(wfcd_pkg::CMD_ADD, 6'd63, 6'd0);
        send_request(wfcd_pkg::CMD_DETECT, 6'd63, 6'd63);   // two-node loop
        send_request(wfcd_pkg::CMD_ADD, 6'd63, 6'd63);      // overwrite into self loop
        send_request(wfcd_pkg::CMD_DETECT, 6'd0, 6'd0);
        send_request(wfcd_pkg::CMD_REMOVE, 6'd63, 6'd0);
        send_request(wfcd_pkg::CMD_DETECT, 6'd0, 6'd0);     // dead end, no cycle
        send_request(CMD_UNUSED, 6'd0, 6'd0);
        send_request(wfcd_pkg::CMD_ADD, 6'd10, 6'd20);
        send_request(wfcd_pkg::CMD_ADD, 6'd20, 6'd30);
        send_request(wfcd_pkg::CMD_ADD, 6'd30, 6'd10);
        send_request(wfcd_pkg::CMD_ADD, 6'd5, 6'd10);       // tail into the loop
        send_request(wfcd_pkg::CMD_DETECT, 6'd0, 6'd0);
        send_request(wfcd_pkg::CMD_ADD, 6'd42, 6'd42);
        send_request(wfcd_pkg::CMD_REMOVE, 6'd30, 6'd0);    // break the loop
        send_request(wfcd_pkg::CMD_DETECT, 6'd0, 6'd0);     // only the self loop left
        send_request(wfcd_pkg::CMD_REMOVE, 6'd42, 6'd0);
        send_request(wfcd_pkg::CMD_DETECT, 6'd0, 6'd0);
        send_request(wfcd_pkg::CMD_REMOVE, 6'd0, 6'd0);
        send_request(wfcd_pkg::CMD_REMOVE, 6'd5, 6'd0);
        send_request(wfcd_pkg::CMD_REMOVE, 6'd10, 6'd0);
        send_request(wfcd_pkg::CMD_REMOVE, 6'd20, 6'd0);
    endtask

    task automatic test_random_graphs();
        while (requests_sent < RANDOM_TARGET)
            run_episode();
    endtask

    // receiver stalls while requests keep coming, so the input backs up
    task automatic test_result_hold_off();
        hold_off_req = 1'b1;
        repeat (12)
            send_request(CMD_W'($urandom_range(0, 3)), rand_id(), rand_id());
    endtask

    // sender idles with the block fully drained, then resumes
    task automatic test_pause_until_drained();
        run_episode();
        wait_drained();
        run_episode();
    endtask

    // final stretch with neither side idling
    task automatic test_back_to_back();
        idle_on = 1'b0;
        while (requests_sent < FINAL_TARGET)
            run_episode();
    endtask

    // result side ready, with random stalls and the requested hold-off
    initial begin : result_sink
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare every accepted result with the oldest expected verdict
    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            results_seen++;
            if (verdict_queue.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result %0d with nothing pending: found=%0b victim=%0d",
                             results_seen, m_found, m_victim);
            end else begin
                want = verdict_queue.pop_front();
                if (m_found !== want.found || m_victim !== want.victim) begin
                    failures++;
                    if (failures <= 10)
                        $display("result %0d: found exp %0b got %0b, victim exp %0d got %0d",
                                 results_seen, want.found, m_found, want.victim, m_victim);
                end
            end
        end
    end

    initial begin : stimulus
        s_valid <= 1'b0;
        s_cmd   <= wfcd_pkg::CMD_ADD;
        s_txn_a <= '0;
        s_txn_b <= '0;
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_graphs();
        test_result_hold_off();
        test_pause_until_drained();
        test_back_to_back();

        // let the last results out, then watch for anything extra
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (verdict_queue.size() != 0) begin
            failures++;
            $display("%0d results never arrived", verdict_queue.size());
        end

        if (failures == 0)
            $display("PASS wait_for_cycle_detector");
        else
            $display("FAIL wait_for_cycle_detector");
        $finish;
    end

    // hang guard, far beyond a run where every request is a worst-case detect
    initial begin : watchdog
        #(64'd1_000_000_000);
        $display("FAIL wait_for_cycle_detector");
        $finish;
    end

endmodule
